### src/ptbv_pkg.sv
package ptbv_pkg;

    localparam int POS_W  = 32;
    localparam int QUAT_W = 16;
    localparam int VEL_W  = 24;
    localparam int LIM_W  = 23;
    localparam int DP_W   = 33;
    localparam int MAG_W  = 32;
    localparam int NUM_W  = 62;
    localparam int WV_W   = 32;
    localparam int ROT_W  = 34;
    localparam int IG_W   = 31;

    localparam logic [29:0] NS_PER_S = 30'd1000000000;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 23'd327680;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FIRST  = 2'd1;
    localparam logic [1:0] STAT_BAD_DT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CORDIC,
        ST_GAIN,
        ST_OUT
    } state_t;

    // Integer square root of the accumulated CORDIC gain squared in Q60.
    function automatic logic [63:0] gain_root(input int steps);
        logic [63:0] p;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        p = 64'd1 << 60;
        for (int i = 0; i < steps; i++) begin
            p = p + (p >> (2 * i));
        end
        v = p;
        res = '0;
        for (int k = 0; k < 32; k++) begin
            bit_w = 64'd1 << (62 - 2 * k);
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

endpackage

### src/ptbv_div.sv
module ptbv_div #(
    parameter int TIME_BITS = 48
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [ptbv_pkg::DP_W-1:0]  dp,
    input  logic        [TIME_BITS-1:0]       dt,
    output logic signed [ptbv_pkg::WV_W-1:0]  vel,
    output logic                              done
);

    localparam int MAG_W   = ptbv_pkg::MAG_W;
    localparam int NUM_W   = ptbv_pkg::NUM_W;
    localparam int CNT_END = MAG_W + NUM_W;
    localparam int CNT_W   = $clog2(CNT_END + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [MAG_W-1:0]       mag_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [TIME_BITS-1:0]   rem_reg;
    logic [31:0]            q_reg;
    logic                   ovf_reg;
    logic                   neg_reg;

    logic                   mul_phase;
    logic [TIME_BITS:0]     rem_sh;
    logic [TIME_BITS:0]     rem_diff;
    logic                   ge;
    logic [TIME_BITS-1:0]   rem_next;
    logic signed [ptbv_pkg::DP_W-1:0] dp_abs;
    logic [31:0]            q_sat;
    logic                   sat;

    always_comb begin
        mul_phase = cnt_reg < CNT_W'(MAG_W);
        rem_sh    = {rem_reg, num_reg[NUM_W-1]};
        rem_diff  = rem_sh - {1'b0, dt};
        ge        = rem_sh >= {1'b0, dt};
        rem_next  = ge ? rem_diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
        dp_abs    = dp[ptbv_pkg::DP_W-1] ? -dp : dp;
        // Anything above 2^30 saturates, including quotient bits lost off the top.
        sat       = ovf_reg || (q_reg > 32'h4000_0000);
        q_sat     = sat ? 32'h4000_0000 : q_reg;
        vel       = neg_reg ? -$signed(q_sat) : $signed(q_sat);
        done      = done_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CNT_END - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // First the magnitude times 1e9 one bit per cycle, then restoring division.
    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= dp_abs[MAG_W-1:0];
            num_reg <= '0;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
            neg_reg <= dp[ptbv_pkg::DP_W-1];
        end else if (busy_reg) begin
            if (mul_phase) begin
                mag_reg <= mag_reg << 1;
                num_reg <= (num_reg << 1)
                         + (mag_reg[MAG_W-1] ? NUM_W'(ptbv_pkg::NS_PER_S) : '0);
            end else begin
                num_reg <= num_reg << 1;
                rem_reg <= rem_next;
                q_reg   <= {q_reg[30:0], ge};
                ovf_reg <= ovf_reg | q_reg[31];
            end
        end
    end

endmodule

### src/ptbv_cordic.sv
module ptbv_cordic #(
    parameter int STEPS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [ptbv_pkg::QUAT_W-1:0]  quat_x,
    input  logic signed [ptbv_pkg::QUAT_W-1:0]  quat_y,
    input  logic signed [ptbv_pkg::QUAT_W-1:0]  quat_z,
    input  logic signed [ptbv_pkg::QUAT_W-1:0]  quat_w,
    input  logic signed [ptbv_pkg::WV_W-1:0]    vx_in,
    input  logic signed [ptbv_pkg::WV_W-1:0]    vy_in,
    output logic signed [ptbv_pkg::ROT_W-1:0]   vx_out,
    output logic signed [ptbv_pkg::ROT_W-1:0]   vy_out,
    output logic                                done
);

    localparam int RW      = ptbv_pkg::ROT_W;
    localparam int QW      = ptbv_pkg::QUAT_W;
    localparam int PRE     = 8;
    localparam int CNT_END = PRE + STEPS;
    localparam int CNT_W   = $clog2(CNT_END + 1);
    localparam int SH_W    = $clog2(STEPS);

    logic                     busy_reg;
    logic                     done_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [2*QW-1:0]   prod_reg;
    logic signed [RW-1:0]     c_reg;
    logic signed [RW-1:0]     s_reg;
    logic signed [RW-1:0]     x_reg;
    logic signed [RW-1:0]     y_reg;

    logic signed [QW-1:0]     op_a;
    logic signed [QW-1:0]     op_b;
    logic [CNT_W-1:0]         step_full;
    logic [SH_W-1:0]          sh;
    logic signed [RW-1:0]     c_sh;
    logic signed [RW-1:0]     s_sh;
    logic signed [RW-1:0]     x_sh;
    logic signed [RW-1:0]     y_sh;
    logic signed [RW-1:0]     prod_ext;
    logic signed [RW-1:0]     s_dbl;

    always_comb begin
        case (cnt_reg)
            CNT_W'(0): begin op_a = quat_w; op_b = quat_w; end
            CNT_W'(1): begin op_a = quat_x; op_b = quat_x; end
            CNT_W'(2): begin op_a = quat_y; op_b = quat_y; end
            CNT_W'(3): begin op_a = quat_z; op_b = quat_z; end
            CNT_W'(4): begin op_a = quat_w; op_b = quat_z; end
            CNT_W'(5): begin op_a = quat_x; op_b = quat_y; end
            default:   begin op_a = '0;     op_b = '0;     end
        endcase
        step_full = cnt_reg - CNT_W'(PRE);
        sh        = step_full[SH_W-1:0];
        c_sh      = c_reg >>> sh;
        s_sh      = s_reg >>> sh;
        x_sh      = x_reg >>> sh;
        y_sh      = y_reg >>> sh;
        prod_ext  = RW'(prod_reg);
        s_dbl     = s_reg <<< 1;
        vx_out    = x_reg;
        vy_out    = y_reg;
        done      = done_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CNT_END - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One product per cycle builds the yaw vector, each accumulated in the cycle after.
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (start) begin
            c_reg <= '0;
            s_reg <= '0;
            x_reg <= RW'(vx_in);
            y_reg <= RW'(vy_in);
        end else if (busy_reg) begin
            if (cnt_reg == CNT_W'(1) || cnt_reg == CNT_W'(2)) begin
                c_reg <= c_reg + prod_ext;
            end else if (cnt_reg == CNT_W'(3) || cnt_reg == CNT_W'(4)) begin
                c_reg <= c_reg - prod_ext;
            end else if (cnt_reg == CNT_W'(5) || cnt_reg == CNT_W'(6)) begin
                s_reg <= s_reg + prod_ext;
            end else if (cnt_reg == CNT_W'(7)) begin
                // A yaw vector in the left half plane is turned by 180 degrees first.
                if (c_reg < 0) begin
                    c_reg <= -c_reg;
                    s_reg <= -s_dbl;
                    x_reg <= -x_reg;
                    y_reg <= -y_reg;
                end else begin
                    s_reg <= s_dbl;
                end
            end else if (cnt_reg >= CNT_W'(PRE)) begin
                if (s_reg >= 0) begin
                    c_reg <= c_reg + s_sh;
                    s_reg <= s_reg - c_sh;
                    x_reg <= x_reg + y_sh;
                    y_reg <= y_reg - x_sh;
                end else begin
                    c_reg <= c_reg - s_sh;
                    s_reg <= s_reg + c_sh;
                    x_reg <= x_reg - y_sh;
                    y_reg <= y_reg + x_sh;
                end
            end
        end
    end

endmodule

### src/ptbv_gain.sv
module ptbv_gain #(
    parameter int STEPS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [ptbv_pkg::ROT_W-1:0]  v,
    input  logic        [ptbv_pkg::LIM_W-1:0]  limit,
    output logic signed [ptbv_pkg::VEL_W-1:0]  vel,
    output logic                               done
);

    localparam int RW      = ptbv_pkg::ROT_W;
    localparam int IG_W    = ptbv_pkg::IG_W;
    localparam int ACC_W   = RW + IG_W + 1;
    localparam int R_W     = ACC_W - 30;
    localparam int CNT_END = IG_W + 1;
    localparam int CNT_W   = $clog2(CNT_END + 1);
    localparam logic [63:0] IG_FULL = (64'd1 << 60) / ptbv_pkg::gain_root(STEPS);

    logic                     busy_reg;
    logic                     done_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [IG_W-1:0]          ig_sh_reg;
    logic signed [RW-1:0]     v_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ptbv_pkg::VEL_W-1:0] vel_reg;

    logic signed [ACC_W-1:0]  r_full;
    logic signed [R_W-1:0]    r;
    logic signed [R_W-1:0]    lim;
    logic                     over;

    always_comb begin
        r_full = acc_reg + (ACC_W'(1) <<< 29);
        r      = $signed(r_full[ACC_W-1:30]);
        lim    = $signed(R_W'(limit));
        over   = (r > lim) || (r < -lim);
        vel    = vel_reg;
        done   = done_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CNT_END - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift-and-add over the inverse gain, most significant bit first,
    // then round half up at bit 30 and apply the limit.
    always_ff @(posedge aclk) begin
        if (start) begin
            ig_sh_reg <= IG_FULL[IG_W-1:0];
            v_reg     <= v;
            acc_reg   <= '0;
        end else if (busy_reg) begin
            if (cnt_reg < CNT_W'(IG_W)) begin
                ig_sh_reg <= ig_sh_reg << 1;
                acc_reg   <= (acc_reg <<< 1)
                           + (ig_sh_reg[IG_W-1] ? ACC_W'(v_reg) : '0);
            end else begin
                vel_reg <= over ? '0 : r[ptbv_pkg::VEL_W-1:0];
            end
        end
    end

endmodule

### src/pose_to_body_velocity.sv
// Channel   Direction  Handshake            Request
// s_        in         s_valid / s_ready    timestamp, planar position, quaternion
// m_        out        m_valid / m_ready    body velocity and status
//
// A valid request passes through the divide, CORDIC and gain states before it reaches
// m_valid, the world velocity coming from the bit-serial multiply and divide; the next
// request can be accepted once its result has been loaded into the output register.
// A first sample or a non-increasing timestamp goes from idle straight to the output
// state, and the next request can follow once its result is in the output register.
// Reset clears the previous pose and sets the speed limit to 5.0 m/s.
// One request is in work at a time; the finished result waits in the output
// register while the next request is taken, and a second finished result stalls
// the input until the first one leaves.
module pose_to_body_velocity #(
    parameter int TIME_BITS    = 48,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic        [ptbv_pkg::LIM_W-1:0]   cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic        [TIME_BITS-1:0]         s_timestamp_ns,
    input  logic signed [ptbv_pkg::POS_W-1:0]   s_pos_x,
    input  logic signed [ptbv_pkg::POS_W-1:0]   s_pos_y,
    input  logic signed [ptbv_pkg::QUAT_W-1:0]  s_quat_x,
    input  logic signed [ptbv_pkg::QUAT_W-1:0]  s_quat_y,
    input  logic signed [ptbv_pkg::QUAT_W-1:0]  s_quat_z,
    input  logic signed [ptbv_pkg::QUAT_W-1:0]  s_quat_w,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ptbv_pkg::VEL_W-1:0]   m_vel_forward,
    output logic signed [ptbv_pkg::VEL_W-1:0]   m_vel_lateral,
    output logic        [1:0]                   m_status
);

    localparam int DP_W = ptbv_pkg::DP_W;
    localparam int QW   = ptbv_pkg::QUAT_W;
    localparam int VW   = ptbv_pkg::VEL_W;

    ptbv_pkg::state_t state_reg, state_next;
    logic                              kick_reg;
    logic [ptbv_pkg::LIM_W-1:0]        speed_limit_reg;
    logic signed [ptbv_pkg::POS_W-1:0] last_x_reg;
    logic signed [ptbv_pkg::POS_W-1:0] last_y_reg;
    logic [TIME_BITS-1:0]              last_time_reg;
    logic                              have_last_reg;
    logic [TIME_BITS-1:0]              dt_reg;
    logic signed [DP_W-1:0]            dpx_reg;
    logic signed [DP_W-1:0]            dpy_reg;
    logic signed [QW-1:0]              qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [VW-1:0]              res_fwd_reg, res_lat_reg;
    logic [1:0]                        res_status_reg;
    logic                              m_valid_reg;
    logic signed [VW-1:0]              m_fwd_reg, m_lat_reg;
    logic [1:0]                        m_status_reg;

    logic                              accept;
    logic [1:0]                        status_in;
    logic                              out_load;
    logic                              div_start, cor_start, gain_start;
    logic signed [ptbv_pkg::WV_W-1:0]  wvx, wvy;
    logic                              divx_done, divy_done;
    logic signed [ptbv_pkg::ROT_W-1:0] bvx, bvy;
    logic                              cor_done;
    logic signed [VW-1:0]              gfwd, glat;
    logic                              gx_done, gy_done;

    always_comb begin
        s_ready   = (state_reg == ptbv_pkg::ST_IDLE);
        accept    = s_valid && s_ready;
        out_load  = (state_reg == ptbv_pkg::ST_OUT) && (!m_valid_reg || m_ready);
        if (!have_last_reg) begin
            status_in = ptbv_pkg::STAT_FIRST;
        end else if (s_timestamp_ns <= last_time_reg) begin
            status_in = ptbv_pkg::STAT_BAD_DT;
        end else begin
            status_in = ptbv_pkg::STAT_OK;
        end
        div_start  = kick_reg && (state_reg == ptbv_pkg::ST_DIV);
        cor_start  = kick_reg && (state_reg == ptbv_pkg::ST_CORDIC);
        gain_start = kick_reg && (state_reg == ptbv_pkg::ST_GAIN);

        state_next = state_reg;
        case (state_reg)
            ptbv_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (status_in == ptbv_pkg::STAT_OK) ? ptbv_pkg::ST_DIV
                                                                  : ptbv_pkg::ST_OUT;
                end
            end
            ptbv_pkg::ST_DIV: begin
                if (divx_done) state_next = ptbv_pkg::ST_CORDIC;
            end
            ptbv_pkg::ST_CORDIC: begin
                if (cor_done) state_next = ptbv_pkg::ST_GAIN;
            end
            ptbv_pkg::ST_GAIN: begin
                if (gx_done) state_next = ptbv_pkg::ST_OUT;
            end
            ptbv_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) state_next = ptbv_pkg::ST_IDLE;
            end
            default: state_next = ptbv_pkg::ST_IDLE;
        endcase

        m_valid       = m_valid_reg;
        m_vel_forward = m_fwd_reg;
        m_vel_lateral = m_lat_reg;
        m_status      = m_status_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ptbv_pkg::ST_IDLE;
            kick_reg        <= 1'b0;
            speed_limit_reg <= ptbv_pkg::LIMIT_RESET;
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            last_time_reg   <= '0;
            have_last_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Each compute unit is started on the first cycle of its state.
            kick_reg  <= (state_next != state_reg);
            if (cfg_we) begin
                speed_limit_reg <= cfg_wdata;
            end
            if (accept) begin
                last_x_reg    <= s_pos_x;
                last_y_reg    <= s_pos_y;
                last_time_reg <= s_timestamp_ns;
                have_last_reg <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            dt_reg         <= s_timestamp_ns - last_time_reg;
            dpx_reg        <= DP_W'(s_pos_x) - DP_W'(last_x_reg);
            dpy_reg        <= DP_W'(s_pos_y) - DP_W'(last_y_reg);
            qx_reg         <= s_quat_x;
            qy_reg         <= s_quat_y;
            qz_reg         <= s_quat_z;
            qw_reg         <= s_quat_w;
            res_fwd_reg    <= '0;
            res_lat_reg    <= '0;
            res_status_reg <= status_in;
        end else if (gx_done) begin
            res_fwd_reg <= gfwd;
            res_lat_reg <= glat;
        end
        if (out_load) begin
            m_fwd_reg    <= res_fwd_reg;
            m_lat_reg    <= res_lat_reg;
            m_status_reg <= res_status_reg;
        end
    end

    ptbv_div #(.TIME_BITS(TIME_BITS)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dp(dpx_reg), .dt(dt_reg), .vel(wvx), .done(divx_done)
    );

    ptbv_div #(.TIME_BITS(TIME_BITS)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dp(dpy_reg), .dt(dt_reg), .vel(wvy), .done(divy_done)
    );

    ptbv_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cor_start),
        .quat_x(qx_reg), .quat_y(qy_reg), .quat_z(qz_reg), .quat_w(qw_reg),
        .vx_in(wvx), .vy_in(wvy), .vx_out(bvx), .vy_out(bvy), .done(cor_done)
    );

    ptbv_gain #(.STEPS(CORDIC_STEPS)) u_gain_fwd (
        .aclk(aclk), .aresetn(aresetn), .start(gain_start),
        .v(bvx), .limit(speed_limit_reg), .vel(gfwd), .done(gx_done)
    );

    ptbv_gain #(.STEPS(CORDIC_STEPS)) u_gain_lat (
        .aclk(aclk), .aresetn(aresetn), .start(gain_start),
        .v(bvy), .limit(speed_limit_reg), .vel(glat), .done(gy_done)
    );

`ifndef SYNTH
    a_bad_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ptbv_pkg::STAT_OK)
            |-> (m_fwd_reg == '0 && m_lat_reg == '0))
        else $error("non-valid status carries a nonzero velocity");

    a_div_lanes_paired: assert property (@(posedge aclk) disable iff (!aresetn)
        divx_done == divy_done)
        else $error("divider lanes out of step");

    a_gain_lanes_paired: assert property (@(posedge aclk) disable iff (!aresetn)
        gx_done == gy_done)
        else $error("gain lanes out of step");

    a_first_sample_short: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !have_last_reg) |=> (state_reg == ptbv_pkg::ST_OUT && have_last_reg))
        else $error("first sample did not go straight to output");

    a_div_done_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        divx_done |-> (state_reg == ptbv_pkg::ST_DIV))
        else $error("divider finished outside its state");
`endif

endmodule

### tb/pose_to_body_velocity_tb.sv
module pose_to_body_velocity_tb;

    localparam int IDLE_LIMIT = 6000;
    localparam int LONG_HOLD  = 900;
    localparam int TAIL_WAIT  = 250;
    localparam longint unsigned NSEC = 64'd1000000000;

    typedef struct packed {
        logic signed [ptbv_pkg::VEL_W-1:0] fwd;
        logic signed [ptbv_pkg::VEL_W-1:0] lat;
        logic [1:0]                        stat;
    } body_vel_t;

    typedef struct {
        logic [47:0]                        ts;
        logic signed [ptbv_pkg::POS_W-1:0]  px;
        logic signed [ptbv_pkg::POS_W-1:0]  py;
        logic signed [ptbv_pkg::QUAT_W-1:0] qx;
        logic signed [ptbv_pkg::QUAT_W-1:0] qy;
        logic signed [ptbv_pkg::QUAT_W-1:0] qz;
        logic signed [ptbv_pkg::QUAT_W-1:0] qw;
        bit                                 typed;
        body_vel_t                          want;
    } pose_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [ptbv_pkg::LIM_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [47:0] s_timestamp_ns = '0;
    logic signed [ptbv_pkg::POS_W-1:0] s_pos_x = '0, s_pos_y = '0;
    logic signed [ptbv_pkg::QUAT_W-1:0] s_quat_x = '0, s_quat_y = '0;
    logic signed [ptbv_pkg::QUAT_W-1:0] s_quat_z = '0, s_quat_w = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [ptbv_pkg::VEL_W-1:0] m_vel_forward, m_vel_lateral;
    logic [1:0] m_status;

    // Side information that travels with the request on the input channel.
    bit        cur_typed = 1'b0;
    body_vel_t cur_want = '0;

    body_vel_t pending_vel[$];
    pose_row_t dir_rows[$];
    int errors = 0;
    int n_sent = 0, n_recv = 0, n_cfg = 0;
    int idle_cnt = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    // Predictor state.
    logic [ptbv_pkg::LIM_W-1:0]        lim_q;
    logic signed [ptbv_pkg::POS_W-1:0] prev_x, prev_y;
    logic [47:0]                       pred_ts;
    bit                                have_prev;
    longint                            inv_gain;

    pose_to_body_velocity dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_timestamp_ns(s_timestamp_ns), .s_pos_x(s_pos_x), .s_pos_y(s_pos_y),
        .s_quat_x(s_quat_x), .s_quat_y(s_quat_y), .s_quat_z(s_quat_z), .s_quat_w(s_quat_w),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_vel_forward(m_vel_forward), .m_vel_lateral(m_vel_lateral), .m_status(m_status)
    );

    always #6 aclk = ~aclk;

    function automatic longint world_speed(longint dp, longint unsigned dt);
        longint unsigned mag;
        longint unsigned q;
        mag = (dp < 0) ? longint'(-dp) : longint'(dp);
        q = mag * NSEC / dt;
        if (q > (64'd1 << 30)) q = 64'd1 << 30;
        return (dp < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip_speed(longint v);
        longint lim;
        lim = longint'(lim_q);
        return (v > lim || v < -lim) ? 0 : v;
    endfunction

    function automatic body_vel_t predict_body_vel(logic [47:0] ts,
                                                   logic signed [ptbv_pkg::POS_W-1:0] px,
                                                   logic signed [ptbv_pkg::POS_W-1:0] py,
                                                   logic signed [ptbv_pkg::QUAT_W-1:0] qx,
                                                   logic signed [ptbv_pkg::QUAT_W-1:0] qy,
                                                   logic signed [ptbv_pkg::QUAT_W-1:0] qz,
                                                   logic signed [ptbv_pkg::QUAT_W-1:0] qw);
        body_vel_t r;
        longint c, s, vx, vy, nc, ns, nvx, nvy;
        longint unsigned dt;
        r = '0;
        if (!have_prev) begin
            r.stat = ptbv_pkg::STAT_FIRST;
        end else if (ts <= pred_ts) begin
            r.stat = ptbv_pkg::STAT_BAD_DT;
        end else begin
            dt = 64'(ts) - 64'(pred_ts);
            vx = world_speed(longint'(px) - longint'(prev_x), dt);
            vy = world_speed(longint'(py) - longint'(prev_y), dt);
            c = longint'(qw) * qw + longint'(qx) * qx - longint'(qy) * qy - longint'(qz) * qz;
            s = 2 * (longint'(qw) * qz + longint'(qx) * qy);
            if (c < 0) begin
                c = -c; s = -s; vx = -vx; vy = -vy;
            end
            for (int i = 0; i < 16; i++) begin
                if (s >= 0) begin
                    nc = c + (s >>> i); ns = s - (c >>> i);
                    nvx = vx + (vy >>> i); nvy = vy - (vx >>> i);
                end else begin
                    nc = c - (s >>> i); ns = s + (c >>> i);
                    nvx = vx - (vy >>> i); nvy = vy + (vx >>> i);
                end
                c = nc; s = ns; vx = nvx; vy = nvy;
            end
            r.stat = ptbv_pkg::STAT_OK;
            r.fwd = ptbv_pkg::VEL_W'(clip_speed((vx * inv_gain + (64'sd1 <<< 29)) >>> 30));
            r.lat = ptbv_pkg::VEL_W'(clip_speed((vy * inv_gain + (64'sd1 <<< 29)) >>> 30));
        end
        prev_x = px;
        prev_y = py;
        pred_ts = ts;
        have_prev = 1'b1;
        return r;
    endfunction

    initial begin
        longint unsigned p, v, root, b;
        p = 64'd1 << 60;
        for (int i = 0; i < 16; i++) p = p + (p >> (2 * i));
        v = p;
        root = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        inv_gain = longint'((64'd1 << 60) / root);
        lim_q = ptbv_pkg::LIMIT_RESET;
        have_prev = 1'b0;
        prev_x = '0;
        prev_y = '0;
        pred_ts = '0;
    end

    // Request and result monitor, predictor hook and watchdog.
    always @(posedge aclk) begin
        body_vel_t pred;
        body_vel_t exp_v;
        if (aresetn) begin
            if (cfg_we) lim_q <= cfg_wdata;
            if (s_valid && s_ready) begin
                pred = predict_body_vel(s_timestamp_ns, s_pos_x, s_pos_y,
                                        s_quat_x, s_quat_y, s_quat_z, s_quat_w);
                pending_vel.push_back(cur_typed ? cur_want : pred);
            end
            if (m_valid && m_ready) begin
                n_recv++;
                if (pending_vel.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result fwd=%0d lat=%0d status=%0d", $time,
                             m_vel_forward, m_vel_lateral, m_status);
                end else begin
                    exp_v = pending_vel.pop_front();
                    if (m_vel_forward !== exp_v.fwd) begin
                        errors++;
                        $display("%0t: vel_forward expected %0d actual %0d", $time,
                                 exp_v.fwd, m_vel_forward);
                    end
                    if (m_vel_lateral !== exp_v.lat) begin
                        errors++;
                        $display("%0t: vel_lateral expected %0d actual %0d", $time,
                                 exp_v.lat, m_vel_lateral);
                    end
                    if (m_status !== exp_v.stat) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_v.stat, m_status);
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cnt <= 0;
            else idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, plus one long hold on request.
    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_pose(pose_row_t r);
        s_valid <= 1'b1;
        s_timestamp_ns <= r.ts;
        s_pos_x <= r.px;
        s_pos_y <= r.py;
        s_quat_x <= r.qx;
        s_quat_y <= r.qy;
        s_quat_z <= r.qz;
        s_quat_w <= r.qw;
        cur_typed <= r.typed;
        cur_want <= r.want;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        n_sent++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_vel.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(logic [ptbv_pkg::LIM_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        n_cfg++;
        @(posedge aclk);
    endtask

    task automatic add_row(logic [47:0] ts, logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [15:0] qx, logic signed [15:0] qy,
                           logic signed [15:0] qz, logic signed [15:0] qw,
                           bit typed, logic [1:0] stat);
        pose_row_t r;
        r.ts = ts; r.px = px; r.py = py;
        r.qx = qx; r.qy = qy; r.qz = qz; r.qw = qw;
        r.typed = typed;
        r.want = '0;
        r.want.stat = stat;
        dir_rows.push_back(r);
    endtask

    function automatic logic signed [15:0] rand_quat();
        return 16'($signed($urandom_range(0, 32768)) - 32'sd16384);
    endfunction

    // Mostly a plausible track with small steps; the rest is noise.
    task automatic random_phase(int count, longint vmax);
        pose_row_t r;
        logic [47:0] ts;
        logic signed [31:0] px, py;
        longint unsigned dt;
        longint dmax;
        ts = 48'd1000;
        px = '0;
        py = '0;
        r.typed = 1'b0;
        r.want = '0;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 12) begin
                case ($urandom_range(0, 2))
                    0: ts = 48'({$urandom, $urandom});
                    1: ts = ts - 48'($urandom_range(0, 1000));
                    default: ;
                endcase
                px = $urandom;
                py = $urandom;
            end else begin
                dt = 64'($urandom_range(1, 20000000));
                if ($urandom_range(0, 30) == 0) dt = 64'($urandom_range(1, 50));
                ts = ts + 48'(dt);
                dmax = longint'(dt) * vmax / 1000000000 + 1;
                px = px + 32'($signed($urandom_range(0, 32'(2 * dmax))) - dmax);
                py = py + 32'($signed($urandom_range(0, 32'(2 * dmax))) - dmax);
            end
            r.ts = ts; r.px = px; r.py = py;
            r.qx = rand_quat(); r.qy = rand_quat(); r.qz = rand_quat(); r.qw = rand_quat();
            if ($urandom_range(0, 9) < 6) begin
                r.qx = 16'($signed($urandom_range(0, 600)) - 300);
                r.qy = 16'($signed($urandom_range(0, 600)) - 300);
            end
            send_pose(r);
        end
    endtask

    initial begin
        body_vel_t zero_v;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        zero_v = '0;
        add_row(48'd5000, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1,
                ptbv_pkg::STAT_FIRST);
        add_row(48'd5000, 32'sd100, 32'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1,
                ptbv_pkg::STAT_BAD_DT);
        add_row(48'd4000, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1,
                ptbv_pkg::STAT_BAD_DT);
        add_row(48'd10004000, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1,
                ptbv_pkg::STAT_OK);
        add_row(48'd20004000, 32'sd20000, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 0, 0);
        add_row(48'd30004000, 32'sd20000, 32'sd20000, 16'sd0, 16'sd0, 16'sd11585,
                16'sd11585, 0, 0);
        add_row(48'd40004000, 32'sd30000, 32'sd20000, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 0, 0);
        add_row(48'd50004000, 32'sd30000, 32'sd30000, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 0, 0);
        add_row(48'd60004000, 32'sd40000, 32'sd40000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0, 0);
        add_row(48'd70004000, 32'sd40000, 32'sd30000, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 0, 0);
        add_row(48'd80004000, 32'sd30000, 32'sd30000, -16'sd16384, -16'sd16384,
                -16'sd16384, -16'sd16384, 0, 0);
        add_row(48'd80004001, -32'sh80000000, 32'sh7fffffff, 16'sd0, 16'sd0, 16'sd0,
                16'sd16384, 0, 0);
        add_row(48'd80004002, 32'sh7fffffff, -32'sh80000000, 16'sd0, 16'sd0, 16'sd0,
                16'sd16384, 0, 0);
        add_row(48'hFFFFFFFFFFFF, 32'sh7fffffff, -32'sh80000000, 16'sd16384, 16'sd16384,
                16'sd16384, 16'sd16384, 0, 0);
        add_row(48'd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1,
                ptbv_pkg::STAT_BAD_DT);
        add_row(48'd1000000000, 32'sd327680, -32'sd327680, 16'sd0, 16'sd0, 16'sd0,
                16'sd16384, 0, 0);
        add_row(48'd2000000000, 32'sd655360, -32'sd655361, 16'sd0, 16'sd0, 16'sd0,
                16'sd16384, 0, 0);
        foreach (dir_rows[i]) send_pose(dir_rows[i]);
        drain_results();

        // Default limit first, then the extremes, a random value and a fixed one for the tail.
        random_phase(400, 8 * 65536);
        drain_results();
        write_limit('0);
        hold_req = 1'b1;
        random_phase(250, 2 * 65536);
        drain_results();
        write_limit(23'd4194304);
        random_phase(400, 100 * 65536);
        drain_results();
        write_limit(23'($urandom_range(0, 4194304)));
        random_phase(400, 30 * 65536);
        drain_results();
        write_limit(23'd200000);
        quiet = 1'b1;
        random_phase(430, 6 * 65536);

        s_valid <= 1'b0;
        while (pending_vel.size() != 0) @(posedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
        $display("Sent %0d poses and checked %0d body velocities over %0d speed limit writes,",
                 n_sent, n_recv, n_cfg);
        $display("with random back-pressure, one long output hold and a no-idle tail.");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
